[src/calibrated_running_stats_defines.svh]
// Assertion macros used by the checker file of calibrated_running_stats.
`ifndef CALIBRATED_RUNNING_STATS_DEFINES_SVH
`define CALIBRATED_RUNNING_STATS_DEFINES_SVH
// Check a consequence in the cycle after the condition.
`define CRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transfer check failed one cycle after the condition");
// Check a consequence in the same cycle as the condition.
`define CRS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transfer check failed in the cycle of the condition");
`endif

[src/crs_pkg.sv]
// Shared types, constants and helpers of the calibrated running statistics block.
`default_nettype none
package crs_pkg;

    localparam int SHORT_WINDOW = 5;
    localparam int LONG_WINDOW  = 20;
    localparam int SW_IDX_W = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
    localparam int SW_CNT_W = $clog2(SHORT_WINDOW + 1);
    localparam int LW_IDX_W = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
    localparam int LW_CNT_W = $clog2(LONG_WINDOW + 1);
    localparam int WSUM_W   = 40;

    localparam logic [1:0] CMD_SAMPLE      = 2'd0;
    localparam logic [1:0] CMD_CLR_SESSION = 2'd1;
    localparam logic [1:0] CMD_CLR_LAP     = 2'd2;
    localparam logic [1:0] CMD_PAUSE       = 2'd3;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_POWER = 2'd1;
    localparam logic [1:0] KIND_SPEED = 2'd2;

    localparam logic [15:0] GAIN_LIM_STD = 16'd8192;
    localparam logic [15:0] GAIN_LIM_ROW = 16'd20480;
    localparam logic [9:0]  RATE_SCALE   = 10'd1000;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_METRIC_KIND  = 3'd0;
    localparam logic [2:0] REG_ROWING       = 3'd1;
    localparam logic [2:0] REG_POWER_GAIN   = 3'd2;
    localparam logic [2:0] REG_POWER_OFFSET = 3'd3;
    localparam logic [2:0] REG_SPEED_GAIN   = 3'd4;
    localparam logic [2:0] REG_SPEED_OFFSET = 3'd5;

    localparam logic [2:0] DIV_RATE    = 3'd0;
    localparam logic [2:0] DIV_SESSION = 3'd1;
    localparam logic [2:0] DIV_LAP     = 3'd2;
    localparam logic [2:0] DIV_SHORT   = 3'd3;
    localparam logic [2:0] DIV_LONG    = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] sample_value;
        logic               apply_calibration;
        logic               accumulate;
        logic               pause_flag;
        logic [31:0]        time_ms;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] current_value;
        logic signed [31:0] rate_per_second;
        logic signed [31:0] session_min;
        logic signed [31:0] session_max;
        logic signed [31:0] lap_min;
        logic signed [31:0] lap_max;
        logic signed [31:0] session_average;
        logic signed [31:0] lap_average;
        logic signed [31:0] short_average;
        logic signed [31:0] long_average;
        logic [31:0]        sample_count;
    } result_t;

    typedef struct packed {
        logic [1:0]         metric_kind;
        logic               rowing_device;
        logic [15:0]        power_gain;
        logic signed [31:0] power_offset;
        logic [15:0]        spd_gain;
        logic signed [31:0] spd_offset;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       val;
        logic       upd;
        logic       div_start;
        logic [2:0] div_sel;
        logic       div_capture;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

    // Clamp a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        logic signed [31:0] r;
        if (x > 65'sh0_7FFF_FFFF)
            r = S32_MAX;
        else if (x < -65'sh0_8000_0000)
            r = S32_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[src/crs_div.sv]
// Radix-2 restoring divider: signed 64-bit dividend, unsigned 32-bit divisor, clamped quotient.
`default_nettype none
module crs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic [5:0]         count_reg;
    logic               neg_reg;
    logic [63:0]        mag_reg;
    logic [63:0]        q_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        div_reg;
    logic signed [31:0] quot_reg;

    logic [32:0]        rem_sh;
    logic               fits;
    logic [32:0]        rem_next;
    logic signed [64:0] q_signed;

    // One quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg[31:0], mag_reg[63]};
        fits     = rem_sh >= {1'b0, div_reg};
        rem_next = fits ? (rem_sh - {1'b0, div_reg}) : rem_sh;
        q_signed = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg  <= (divisor != 32'd0);
                fin_reg   <= (divisor == 32'd0);
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 6'd1;
                if (count_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[63];
            mag_reg <= dividend[63] ? (~dividend + 64'd1) : dividend;
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], fits};
        end
        if (fin_reg)
            quot_reg <= crs_pkg::sat32(q_signed);
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

[src/crs_datapath.sv]
// Datapath: calibration, statistics state, moving windows, shared divider and result register.
`default_nettype none
module crs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crs_pkg::cfg_t        cfg,
    input  crs_pkg::sample_t     sample,
    input  crs_pkg::dp_cmd_t     cmd,
    output crs_pkg::dp_status_t  status,
    output crs_pkg::result_t     result,
    output logic                 result_valid,
    input  logic                 result_ready
);

    // Saturating 64-bit accumulate of a 32-bit term.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [31:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {{33{b[31]}}, b};
        if (s[64] != s[63])
            r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            r = s[63:0];
        return r;
    endfunction

    crs_pkg::sample_t   item_reg;
    logic [46:0]        prod_reg;
    logic signed [31:0] val_reg;

    logic signed [31:0] stored_reg;
    logic signed [31:0] accum_reg;
    logic [31:0]        last_time_reg;
    logic signed [31:0] rate_reg;
    logic [31:0]        s_count_reg;
    logic [31:0]        l_count_reg;
    logic signed [63:0] s_sum_reg;
    logic signed [63:0] l_sum_reg;
    logic signed [31:0] s_min_reg;
    logic signed [31:0] s_max_reg;
    logic signed [31:0] l_min_reg;
    logic signed [31:0] l_max_reg;
    logic signed [31:0] short_buf [crs_pkg::SHORT_WINDOW];
    logic signed [31:0] long_buf [crs_pkg::LONG_WINDOW];
    logic [crs_pkg::SW_CNT_W-1:0] s_fill_reg;
    logic [crs_pkg::SW_IDX_W-1:0] s_head_reg;
    logic [crs_pkg::LW_CNT_W-1:0] l_fill_reg;
    logic [crs_pkg::LW_IDX_W-1:0] l_head_reg;
    logic signed [crs_pkg::WSUM_W-1:0] s_wsum_reg;
    logic signed [crs_pkg::WSUM_W-1:0] l_wsum_reg;
    logic               paused_reg;
    logic               rate_need_reg;
    logic signed [63:0] rate_prod_reg;
    logic [31:0]        gap_reg;
    logic signed [31:0] s_avg_reg;
    logic signed [31:0] l_avg_reg;
    logic signed [31:0] sh_avg_reg;
    logic signed [31:0] lg_avg_reg;
    crs_pkg::result_t   result_reg;
    logic               result_valid_reg;

    logic [15:0]        gain_sel;
    logic [15:0]        gain_lim;
    logic signed [31:0] scaled;
    logic signed [31:0] gained;
    logic signed [31:0] offset_sel;
    logic signed [31:0] offs_sum;
    logic               cal_on;
    logic signed [31:0] val_next;

    logic signed [32:0] diff33;
    logic signed [43:0] rate_prod_w;
    logic [31:0]        gap_next;
    logic signed [32:0] d33;
    logic signed [31:0] d32;
    logic signed [32:0] cur33;
    logic               take;
    logic               s_full;
    logic               l_full;
    logic signed [crs_pkg::WSUM_W-1:0] s_wsum_next;
    logic signed [crs_pkg::WSUM_W-1:0] l_wsum_next;
    logic [crs_pkg::SW_IDX_W-1:0] s_head_next;
    logic [crs_pkg::LW_IDX_W-1:0] l_head_next;

    logic signed [63:0] div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic signed [31:0] div_q;

    // Select the calibration gain and the power gain limit
    always_comb
    begin
        gain_sel = (cfg.metric_kind == crs_pkg::KIND_SPEED) ? cfg.spd_gain : cfg.power_gain;
        gain_lim = cfg.rowing_device ? crs_pkg::GAIN_LIM_ROW : crs_pkg::GAIN_LIM_STD;
    end

    // Finish calibration: clamp the scaled value (or skip an over-limit power gain), add offset, clamp again
    always_comb
    begin
        scaled = (|prod_reg[46:43]) ? crs_pkg::S32_MAX : $signed({1'b0, prod_reg[42:12]});
        if (cfg.metric_kind == crs_pkg::KIND_POWER && cfg.power_gain > gain_lim)
            gained = item_reg.sample_value;
        else
            gained = scaled;
        offset_sel = (cfg.metric_kind == crs_pkg::KIND_POWER) ? cfg.power_offset
                                                               : cfg.spd_offset;
        offs_sum = crs_pkg::sat32({{33{gained[31]}}, gained}
                                  + {{33{offset_sel[31]}}, offset_sel});
        cal_on = item_reg.apply_calibration && (item_reg.sample_value > 32'sd0)
                 && (cfg.metric_kind == crs_pkg::KIND_POWER
                     || cfg.metric_kind == crs_pkg::KIND_SPEED);
        val_next = cal_on ? offs_sum : item_reg.sample_value;
    end

    // Rate operands, accumulated term and window updates
    always_comb
    begin
        diff33      = {val_reg[31], val_reg} - {stored_reg[31], stored_reg};
        rate_prod_w = diff33 * $signed({1'b0, crs_pkg::RATE_SCALE});
        gap_next    = (item_reg.time_ms > last_time_reg) ? (item_reg.time_ms - last_time_reg)
                                                         : (last_time_reg - item_reg.time_ms);
        d33   = {val_reg[31], val_reg} - {accum_reg[31], accum_reg};
        d32   = crs_pkg::sat32({{32{d33[32]}}, d33});
        cur33 = {stored_reg[31], stored_reg} - {accum_reg[31], accum_reg};
        take  = (item_reg.cmd == crs_pkg::CMD_SAMPLE) && !paused_reg && (d33 != 33'sd0);

        s_full = s_fill_reg >= crs_pkg::SW_CNT_W'(crs_pkg::SHORT_WINDOW);
        l_full = l_fill_reg >= crs_pkg::LW_CNT_W'(crs_pkg::LONG_WINDOW);
        s_wsum_next = s_wsum_reg + crs_pkg::WSUM_W'(d32)
                      - (s_full ? crs_pkg::WSUM_W'(short_buf[s_head_reg])
                                : {crs_pkg::WSUM_W{1'b0}});
        l_wsum_next = l_wsum_reg + crs_pkg::WSUM_W'(d32)
                      - (l_full ? crs_pkg::WSUM_W'(long_buf[l_head_reg])
                                : {crs_pkg::WSUM_W{1'b0}});
        s_head_next = (s_head_reg == crs_pkg::SW_IDX_W'(crs_pkg::SHORT_WINDOW - 1))
                      ? '0 : s_head_reg + 1'b1;
        l_head_next = (l_head_reg == crs_pkg::LW_IDX_W'(crs_pkg::LONG_WINDOW - 1))
                      ? '0 : l_head_reg + 1'b1;
    end

    // Item, product and operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= sample;
        if (cmd.mul)
            prod_reg <= item_reg.sample_value[30:0] * gain_sel;
        if (cmd.val)
            val_reg <= val_next;
        if (cmd.upd)
        begin
            rate_prod_reg <= {{20{rate_prod_w[43]}}, rate_prod_w};
            gap_reg       <= gap_next;
        end
        if (cmd.upd && take)
        begin
            short_buf[s_head_reg] <= d32;
            long_buf[l_head_reg]  <= d32;
        end
    end

    // Statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg    <= '0;
            accum_reg     <= '0;
            last_time_reg <= '0;
            rate_reg      <= '0;
            s_count_reg   <= '0;
            l_count_reg   <= '0;
            s_sum_reg     <= '0;
            l_sum_reg     <= '0;
            s_min_reg     <= crs_pkg::S32_MAX;
            s_max_reg     <= '0;
            l_min_reg     <= crs_pkg::S32_MAX;
            l_max_reg     <= '0;
            s_fill_reg    <= '0;
            s_head_reg    <= '0;
            l_fill_reg    <= '0;
            l_head_reg    <= '0;
            s_wsum_reg    <= '0;
            l_wsum_reg    <= '0;
            paused_reg    <= 1'b0;
            rate_need_reg <= 1'b0;
        end
        else if (cmd.upd)
        begin
            rate_need_reg <= 1'b0;
            case (item_reg.cmd)
                crs_pkg::CMD_SAMPLE:
                begin
                    rate_need_reg <= (val_reg != stored_reg)
                                     && (s_fill_reg > crs_pkg::SW_CNT_W'(1));
                    stored_reg    <= val_reg;
                    last_time_reg <= item_reg.time_ms;
                    if (take)
                    begin
                        if (s_count_reg != 32'hFFFF_FFFF)
                            s_count_reg <= s_count_reg + 32'd1;
                        if (l_count_reg != 32'hFFFF_FFFF)
                            l_count_reg <= l_count_reg + 32'd1;
                        s_sum_reg  <= sat_add64(s_sum_reg, d32);
                        l_sum_reg  <= sat_add64(l_sum_reg, d32);
                        s_wsum_reg <= s_wsum_next;
                        l_wsum_reg <= l_wsum_next;
                        s_head_reg <= s_head_next;
                        l_head_reg <= l_head_next;
                        if (!s_full)
                            s_fill_reg <= s_fill_reg + 1'b1;
                        if (!l_full)
                            l_fill_reg <= l_fill_reg + 1'b1;
                        if (d32 < s_min_reg)
                            s_min_reg <= d32;
                        if (d32 < l_min_reg)
                            l_min_reg <= d32;
                        if (d32 > s_max_reg)
                            s_max_reg <= d32;
                        if (d32 > l_max_reg)
                            l_max_reg <= d32;
                    end
                end
                crs_pkg::CMD_CLR_SESSION:
                begin
                    if (item_reg.accumulate)
                        accum_reg <= stored_reg;
                    s_min_reg   <= crs_pkg::S32_MAX;
                    s_max_reg   <= '0;
                    s_sum_reg   <= '0;
                    s_count_reg <= '0;
                    s_fill_reg  <= '0;
                    s_head_reg  <= '0;
                    l_fill_reg  <= '0;
                    l_head_reg  <= '0;
                    s_wsum_reg  <= '0;
                    l_wsum_reg  <= '0;
                    l_min_reg   <= crs_pkg::S32_MAX;
                    l_max_reg   <= '0;
                    l_sum_reg   <= '0;
                    l_count_reg <= '0;
                end
                crs_pkg::CMD_CLR_LAP:
                begin
                    l_min_reg   <= crs_pkg::S32_MAX;
                    l_max_reg   <= '0;
                    l_sum_reg   <= '0;
                    l_count_reg <= '0;
                end
                crs_pkg::CMD_PAUSE:
                begin
                    paused_reg <= item_reg.pause_flag;
                end
                default:
                begin
                    paused_reg <= paused_reg;
                end
            endcase
        end
        else if (cmd.div_capture && cmd.div_sel == crs_pkg::DIV_RATE && rate_need_reg)
        begin
            rate_reg <= div_q;
        end
    end

    // Route operands to the shared divider
    always_comb
    begin
        case (cmd.div_sel)
            crs_pkg::DIV_RATE:
            begin
                div_dividend = rate_prod_reg;
                div_divisor  = gap_reg;
            end
            crs_pkg::DIV_SESSION:
            begin
                div_dividend = s_sum_reg;
                div_divisor  = s_count_reg;
            end
            crs_pkg::DIV_LAP:
            begin
                div_dividend = l_sum_reg;
                div_divisor  = l_count_reg;
            end
            crs_pkg::DIV_SHORT:
            begin
                div_dividend = 64'(s_wsum_reg);
                div_divisor  = 32'(s_fill_reg);
            end
            crs_pkg::DIV_LONG:
            begin
                div_dividend = 64'(l_wsum_reg);
                div_divisor  = 32'(l_fill_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    crs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Capture averages and load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.div_capture)
        begin
            case (cmd.div_sel)
                crs_pkg::DIV_SESSION: s_avg_reg  <= div_q;
                crs_pkg::DIV_LAP:     l_avg_reg  <= div_q;
                crs_pkg::DIV_SHORT:   sh_avg_reg <= div_q;
                crs_pkg::DIV_LONG:    lg_avg_reg <= div_q;
                default:              s_avg_reg  <= s_avg_reg;
            endcase
        end
        if (cmd.out_load)
        begin
            result_reg.current_value   <= crs_pkg::sat32({{32{cur33[32]}}, cur33});
            result_reg.rate_per_second <= rate_reg;
            result_reg.session_min     <= s_min_reg;
            result_reg.session_max     <= s_max_reg;
            result_reg.lap_min         <= l_min_reg;
            result_reg.lap_max         <= l_max_reg;
            result_reg.session_average <= s_avg_reg;
            result_reg.lap_average     <= l_avg_reg;
            result_reg.short_average   <= sh_avg_reg;
            result_reg.long_average    <= lg_avg_reg;
            result_reg.sample_count    <= s_count_reg;
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.out_load)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    // Report divider and output register status
    always_comb
    begin
        status.div_done = div_done;
        status.out_free = !result_valid_reg || result_ready;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule
`default_nettype wire

[src/crs_ctrl.sv]
// Controller: sequences load, calibration, update, five divisions and the result hand-off.
`default_nettype none
module crs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  crs_pkg::dp_status_t status,
    output crs_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_VAL    = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_DSTART = 3'd4;
    localparam logic [2:0] S_DWAIT  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] sel_reg;
    logic [2:0] sel_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        cmd             = '0;
        cmd.div_sel     = sel_reg;
        sample_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_VAL;
            end
            S_VAL:
            begin
                cmd.val    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                sel_next   = crs_pkg::DIV_RATE;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    if (sel_reg == crs_pkg::DIV_LONG)
                        state_next = S_OUT;
                    else
                    begin
                        sel_next   = sel_reg + 3'd1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= crs_pkg::DIV_RATE;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule
`default_nettype wire

[src/calibrated_running_stats.sv]
// Calibrated running statistics of a timestamped Q24.8 sensor value. Each transfer on the
// sample channel is one command (sample, clear session, clear lap, set pause) and produces
// exactly one result transfer carrying all statistics after that command. One item is
// processed at a time: it is accepted, then goes through calibration multiply, calibration
// finish and state update, then five divisions (rate, session, lap, short and long window
// averages) through one shared radix-2 divider, and the result is handed to the output
// register once the previous result has been taken. The output register lets the next
// sample be accepted while a result still waits. Configuration must be written over the
// APB port only while the block is idle; the block itself does not enforce this. All
// registers read back.
`default_nettype none
module calibrated_running_stats (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  crs_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_ready,
    output crs_pkg::result_t                result
);

    crs_pkg::cfg_t       cfg_reg;
    crs_pkg::dp_cmd_t    dp_cmd;
    crs_pkg::dp_status_t dp_status;
    logic [2:0]          reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.metric_kind   <= crs_pkg::KIND_PLAIN;
            cfg_reg.rowing_device <= 1'b0;
            cfg_reg.power_gain    <= 16'd4096;
            cfg_reg.power_offset  <= '0;
            cfg_reg.spd_gain      <= 16'd4096;
            cfg_reg.spd_offset    <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_index)
                crs_pkg::REG_METRIC_KIND:  cfg_reg.metric_kind   <= pwdata[1:0];
                crs_pkg::REG_ROWING:       cfg_reg.rowing_device <= pwdata[0];
                crs_pkg::REG_POWER_GAIN:   cfg_reg.power_gain    <= pwdata[15:0];
                crs_pkg::REG_POWER_OFFSET: cfg_reg.power_offset  <= pwdata;
                crs_pkg::REG_SPEED_GAIN:   cfg_reg.spd_gain      <= pwdata[15:0];
                crs_pkg::REG_SPEED_OFFSET: cfg_reg.spd_offset    <= pwdata;
                default:                   cfg_reg.metric_kind   <= cfg_reg.metric_kind;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_index)
            crs_pkg::REG_METRIC_KIND:  prdata = {30'd0, cfg_reg.metric_kind};
            crs_pkg::REG_ROWING:       prdata = {31'd0, cfg_reg.rowing_device};
            crs_pkg::REG_POWER_GAIN:   prdata = {16'd0, cfg_reg.power_gain};
            crs_pkg::REG_POWER_OFFSET: prdata = cfg_reg.power_offset;
            crs_pkg::REG_SPEED_GAIN:   prdata = {16'd0, cfg_reg.spd_gain};
            crs_pkg::REG_SPEED_OFFSET: prdata = cfg_reg.spd_offset;
            default:                   prdata = '0;
        endcase
    end

    crs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (dp_status),
        .cmd          (dp_cmd)
    );

    crs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample       (sample),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
`default_nettype wire

[src/crs_checker.sv]
// Port-level checker for calibrated_running_stats, with its bind.
`default_nettype none
`include "calibrated_running_stats_defines.svh"
module crs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_ready,
    input logic             result_valid,
    input logic             result_ready,
    input crs_pkg::result_t result
);

    // Hold a stalled result
    `CRS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
    `CRS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result))
    // Stop taking samples while one is in work
    `CRS_ASSERT_NEXT(a_busy_after_take, sample_valid && sample_ready, !sample_ready)
    // A result never follows its sample in the next cycle
    `CRS_ASSERT_NEXT(a_no_instant_result, sample_valid && sample_ready && !result_valid,
                     !result_valid)
    // A new result leaves the block ready for the next sample
    `CRS_ASSERT_SAME(a_ready_on_result, $rose(result_valid), sample_ready)

endmodule

bind calibrated_running_stats crs_checker u_crs_checker (.*);
`default_nettype wire

[bench/calibrated_running_stats_tb.sv]
// Testbench for calibrated_running_stats: random and directed commands checked against a predictor.
`timescale 1ns / 1ps
module calibrated_running_stats_tb;

    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;
    localparam longint CNT_CAP = 64'sd4294967295;
    localparam int NUM_PHASES = 5;
    localparam int RANDOM_PER_PHASE = 240;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [crs_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic sample_valid = 1'b0;
    logic sample_ready;
    crs_pkg::sample_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    crs_pkg::result_t result;

    calibrated_running_stats DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Calibration mirror
    logic [1:0] cal_kind = crs_pkg::KIND_PLAIN;
    logic cal_rowing = 1'b0;
    longint cal_pgain = 4096, cal_poff = 0, cal_sgain = 4096, cal_soff = 0;

    // Statistics mirror
    longint cur_val, zero_base, last_ms, rate_q;
    longint sess_cnt, lap_cnt, sess_sum, lap_sum;
    longint sess_lo, sess_hi, lap_lo, lap_hi;
    longint win_buf[2][64];
    longint win_sum[2];
    int win_fill[2], win_head[2];
    int win_len[2] = '{crs_pkg::SHORT_WINDOW, crs_pkg::LONG_WINDOW};
    bit paused;

    crs_pkg::sample_t pending_samples[$];
    crs_pkg::result_t expected_stats[$];
    int send_idle_pct = 0, recv_stall_pct = 0;
    int driven_cnt = 0, accepted_cnt = 0, checked_cnt = 0, error_cnt = 0;
    longint clock_ms = 0;

    function automatic longint clamp32(longint x);
        return (x > MAX32) ? MAX32 : ((x < MIN32) ? MIN32 : x);
    endfunction

    function automatic longint add_sat64(longint a, longint b);
        longint s;
        s = a + b;
        if (b > 0 && s < a) s = 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && s > a) s = 64'sh8000_0000_0000_0000;
        return s;
    endfunction

    function automatic longint avg32(longint sum, longint n);
        return (n == 0) ? 0 : clamp32(sum / n);
    endfunction

    function automatic void clear_lap_stats();
        lap_lo = MAX32;
        lap_hi = 0;
        lap_sum = 0;
        lap_cnt = 0;
    endfunction

    function automatic void clear_session_stats(bit take_base);
        if (take_base) zero_base = cur_val;
        sess_lo = MAX32;
        sess_hi = 0;
        sess_sum = 0;
        sess_cnt = 0;
        for (int k = 0; k < 2; k++)
        begin
            win_fill[k] = 0;
            win_head[k] = 0;
            win_sum[k] = 0;
        end
        clear_lap_stats();
    endfunction

    function automatic longint calibrated(longint v);
        longint lim;
        if (v <= 0) return v;
        if (cal_kind == crs_pkg::KIND_POWER)
        begin
            lim = cal_rowing ? longint'(crs_pkg::GAIN_LIM_ROW) : longint'(crs_pkg::GAIN_LIM_STD);
            if (cal_pgain <= lim) v = clamp32((v * cal_pgain) >>> 12);
            return clamp32(v + cal_poff);
        end
        if (cal_kind == crs_pkg::KIND_SPEED)
        begin
            v = clamp32((v * cal_sgain) >>> 12);
            return clamp32(v + cal_soff);
        end
        return v;
    endfunction

    // Apply one command to the mirror and return the statistics it reports.
    function automatic crs_pkg::result_t predict_stats(crs_pkg::sample_t s);
        crs_pkg::result_t r;
        longint v, t, gap, d;
        int h;
        case (s.cmd)
            crs_pkg::CMD_SAMPLE:
            begin
                v = longint'(s.sample_value);
                t = longint'(s.time_ms);
                if (s.apply_calibration) v = calibrated(v);
                if (v != cur_val && win_fill[0] > 1)
                begin
                    gap = (t > last_ms) ? t - last_ms : last_ms - t;
                    rate_q = (gap != 0) ? clamp32((v - cur_val) * 1000 / gap) : 0;
                end
                last_ms = t;
                cur_val = v;
                d = cur_val - zero_base;
                if (!paused && d != 0)
                begin
                    d = clamp32(d);
                    if (sess_cnt != CNT_CAP) sess_cnt++;
                    if (lap_cnt != CNT_CAP) lap_cnt++;
                    sess_sum = add_sat64(sess_sum, d);
                    lap_sum = add_sat64(lap_sum, d);
                    for (int k = 0; k < 2; k++)
                    begin
                        h = win_head[k] % win_len[k];
                        if (win_fill[k] >= win_len[k]) win_sum[k] -= win_buf[k][h];
                        win_buf[k][h] = d;
                        win_sum[k] += d;
                        win_head[k] = (h + 1) % win_len[k];
                        if (win_fill[k] < win_len[k]) win_fill[k]++;
                    end
                    if (d < sess_lo) sess_lo = d;
                    if (d < lap_lo) lap_lo = d;
                    if (d > sess_hi) sess_hi = d;
                    if (d > lap_hi) lap_hi = d;
                end
            end
            crs_pkg::CMD_CLR_SESSION: clear_session_stats(s.accumulate);
            crs_pkg::CMD_CLR_LAP: clear_lap_stats();
            default: paused = s.pause_flag;
        endcase
        r.current_value = 32'(clamp32(cur_val - zero_base));
        r.rate_per_second = 32'(rate_q);
        r.session_min = 32'(sess_lo);
        r.session_max = 32'(sess_hi);
        r.lap_min = 32'(lap_lo);
        r.lap_max = 32'(lap_hi);
        r.session_average = 32'(avg32(sess_sum, sess_cnt));
        r.lap_average = 32'(avg32(lap_sum, lap_cnt));
        r.short_average = 32'(avg32(win_sum[0], longint'(win_fill[0])));
        r.long_average = 32'(avg32(win_sum[1], longint'(win_fill[1])));
        r.sample_count = sess_cnt[31:0];
        return r;
    endfunction

    // Record each accepted command and predict its result
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
        begin
            expected_stats.push_back(predict_stats(sample));
            accepted_cnt++;
        end
    end

    // Drive commands: hold until the transfer completes, then maybe idle
    always @(negedge clk)
    begin
        if (rst_n && (!sample_valid || accepted_cnt == driven_cnt))
        begin
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample <= pending_samples.pop_front();
                sample_valid <= 1'b1;
                driven_cnt++;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        if (rst_n)
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %h, got %h", name, exp, act);
            error_cnt++;
        end
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        crs_pkg::result_t exp;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_stats.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                error_cnt++;
            end
            else
            begin
                exp = expected_stats.pop_front();
                checked_cnt++;
                check_field("current_value", exp.current_value, result.current_value);
                check_field("rate_per_second", exp.rate_per_second, result.rate_per_second);
                check_field("session_min", exp.session_min, result.session_min);
                check_field("session_max", exp.session_max, result.session_max);
                check_field("lap_min", exp.lap_min, result.lap_min);
                check_field("lap_max", exp.lap_max, result.lap_max);
                check_field("session_average", exp.session_average, result.session_average);
                check_field("lap_average", exp.lap_average, result.lap_average);
                check_field("short_average", exp.short_average, result.short_average);
                check_field("long_average", exp.long_average, result.long_average);
                check_field("sample_count", exp.sample_count, result.sample_count);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= crs_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            crs_pkg::REG_METRIC_KIND: cal_kind = data[1:0];
            crs_pkg::REG_ROWING: cal_rowing = data[0];
            crs_pkg::REG_POWER_GAIN: cal_pgain = longint'(data[15:0]);
            crs_pkg::REG_POWER_OFFSET: cal_poff = longint'(signed'(data));
            crs_pkg::REG_SPEED_GAIN: cal_sgain = longint'(data[15:0]);
            crs_pkg::REG_SPEED_OFFSET: cal_soff = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic queue_cmd(logic [1:0] cmd, logic [31:0] value, bit cal, bit acc,
                             bit pause, logic [31:0] ms);
        crs_pkg::sample_t s;
        s.cmd = cmd;
        s.sample_value = value;
        s.apply_calibration = cal;
        s.accumulate = acc;
        s.pause_flag = pause;
        s.time_ms = ms;
        pending_samples.push_back(s);
    endtask

    task automatic queue_random();
        logic [1:0] cmd;
        logic [31:0] value, ms;
        int pick;
        pick = $urandom_range(0, 99);
        cmd = (pick < 82) ? crs_pkg::CMD_SAMPLE : (pick < 86) ? crs_pkg::CMD_CLR_SESSION :
              (pick < 92) ? crs_pkg::CMD_CLR_LAP : crs_pkg::CMD_PAUSE;
        case ($urandom_range(0, 9))
            0: value = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: value = $urandom_range(0, 2) - 1;
            2, 3: value = $urandom;
            default: value = $urandom_range(0, 200000) - 20000;
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0)
            clock_ms = longint'($urandom);
        else if (pick > 1)
            clock_ms = (clock_ms + longint'($urandom_range(1, 3000))) & 64'hFFFF_FFFF;
        ms = clock_ms[31:0];
        queue_cmd(cmd, value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 99) < 30), ms);
    endtask

    // Hold off until every command has been answered, then let the block settle
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_valid || expected_stats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        paused = 0;
        cur_val = 0;
        zero_base = 0;
        last_ms = 0;
        rate_q = 0;
        clear_session_stats(0);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every command, zero and backward time gaps, pause, baseline
        send_idle_pct = 34;
        recv_stall_pct = 56;
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'd0, 0, 0, 0, 32'd0);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'd256, 0, 0, 0, 32'd100);
        queue_cmd(crs_pkg::CMD_SAMPLE, -32'sd256, 0, 0, 0, 32'd200);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 0, 0, 0, 32'd300);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'h8000_0000, 0, 0, 0, 32'd300);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'd1000, 0, 0, 0, 32'd50);
        queue_cmd(crs_pkg::CMD_PAUSE, 32'd0, 0, 0, 1, 32'd0);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'd777, 1, 0, 0, 32'd400);
        queue_cmd(crs_pkg::CMD_PAUSE, 32'd0, 0, 0, 0, 32'd0);
        queue_cmd(crs_pkg::CMD_CLR_LAP, 32'd0, 0, 1, 0, 32'd0);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'd5, 0, 0, 0, 32'd500);
        queue_cmd(crs_pkg::CMD_CLR_SESSION, 32'd0, 0, 1, 0, 32'd0);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'd5, 0, 0, 0, 32'd600);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'h8000_0000, 0, 0, 0, 32'd700);
        queue_cmd(crs_pkg::CMD_SAMPLE, 32'h7FFF_FFFF, 1, 0, 0, 32'hFFFF_FFFF);
        queue_cmd(crs_pkg::CMD_CLR_SESSION, 32'd0, 0, 0, 0, 32'd0);
        for (int i = 0; i < 7; i++)
            queue_cmd(crs_pkg::CMD_SAMPLE, 32'd100 * (i + 1), 0, 0, 0, 32'd1000 * i);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = (p == 0) ? 34 : (p == 1) ? 56 : 0;
            recv_stall_pct = (p == 0) ? 56 : (p == 1) ? 34 : 0;
            case (p)
                1:
                begin
                    write_reg(crs_pkg::REG_METRIC_KIND, 32'(crs_pkg::KIND_POWER));
                    write_reg(crs_pkg::REG_ROWING, 32'd0);
                    write_reg(crs_pkg::REG_POWER_GAIN, 32'(crs_pkg::GAIN_LIM_STD));
                    write_reg(crs_pkg::REG_POWER_OFFSET, 32'h8000_0000);
                    write_reg(crs_pkg::REG_SPEED_GAIN, 32'd0);
                    write_reg(crs_pkg::REG_SPEED_OFFSET, 32'h7FFF_FFFF);
                end
                2:
                begin
                    write_reg(crs_pkg::REG_METRIC_KIND, 32'(crs_pkg::KIND_SPEED));
                    write_reg(crs_pkg::REG_ROWING, 32'd1);
                    write_reg(crs_pkg::REG_POWER_GAIN, 32'(crs_pkg::GAIN_LIM_ROW) + 32'd1);
                    write_reg(crs_pkg::REG_SPEED_GAIN, 32'd65535);
                    write_reg(crs_pkg::REG_SPEED_OFFSET, 32'h8000_0000);
                end
                3:
                begin
                    write_reg(crs_pkg::REG_METRIC_KIND, 32'(crs_pkg::KIND_POWER));
                    write_reg(crs_pkg::REG_POWER_GAIN, 32'(crs_pkg::GAIN_LIM_ROW));
                    write_reg(crs_pkg::REG_POWER_OFFSET, 32'h7FFF_FFFF);
                end
                4:
                begin
                    write_reg(crs_pkg::REG_METRIC_KIND, 32'd3);
                    write_reg(crs_pkg::REG_POWER_GAIN, 32'd65535);
                    write_reg(crs_pkg::REG_SPEED_GAIN, 32'd5000);
                    write_reg(crs_pkg::REG_SPEED_OFFSET, -32'sd1234);
                end
                default: ;
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                queue_random();
            wait_idle();
        end

        $display("Sent %0d commands through %0d calibration settings; %0d results compared.",
                 accepted_cnt, NUM_PHASES, checked_cnt);
        if (error_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50ms;
        $display("Timed out with %0d results outstanding.", expected_stats.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[calibrated_running_stats.f]
+incdir+src
src/crs_pkg.sv
src/crs_div.sv
src/crs_datapath.sv
src/crs_ctrl.sv
src/calibrated_running_stats.sv
src/crs_checker.sv
bench/calibrated_running_stats_tb.sv
